### rtl/core/rshd_pkg.sv
// ----------------------------------------------------------------------------
// rshd_pkg
// Shared constants, operation and result codes, and the stored region record
// for the region stack hit dispatcher.
// ----------------------------------------------------------------------------
package rshd_pkg;

  localparam int NREG       = 16;
  localparam int IDXW       = $clog2(NREG);
  localparam int CNTW       = $clog2(NREG + 1);
  localparam int COORD_BITS = 12;
  localparam int SLOT_W     = 4;
  localparam int MOD_W      = 8;
  localparam int EV_W       = 11;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_RAISE = 3'd2;
  localparam logic [OP_W-1:0] OP_LOWER = 3'd3;
  localparam logic [OP_W-1:0] OP_EVENT = 3'd4;

  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LEAVE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENTER   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEFAULT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd6;

  localparam logic [EV_W-1:0] EV_MOVE  = 11'd1;
  localparam logic [EV_W-1:0] EV_DOWN  = 11'd4;
  localparam logic [EV_W-1:0] EV_ENTER = 11'd512;
  localparam logic [EV_W-1:0] EV_LEAVE = 11'd1024;

  localparam logic [EV_W-1:0] BARE_MASK_RST = 11'd1551;

  localparam logic CFG_DEFAULT = 1'b0;
  localparam logic CFG_BARE    = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] xlo;
    logic [COORD_BITS-1:0] ylo;
    logic [COORD_BITS-1:0] xhi;
    logic [COORD_BITS-1:0] yhi;
    logic [MOD_W-1:0]      min_mod;
    logic [MOD_W-1:0]      max_mod;
    logic [EV_W-1:0]       mask;
  } region_t;

  localparam int RGN_W = $bits(region_t);

endpackage

### rtl/core/rshd_ram.sv
// ----------------------------------------------------------------------------
// rshd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rshd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rshd_match.sv
// ----------------------------------------------------------------------------
// rshd_match
// Hit test of one stored region against a pointer position and modifiers.
// ----------------------------------------------------------------------------
module rshd_match
  import rshd_pkg::*;
(
  input  region_t               rgn_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  logic [MOD_W-1:0]      mods_i,
  output logic                  hit_o
);

  logic in_x, in_y, min_ok, max_ok;

  assign in_x   = (rgn_i.xlo <= x_i) && (rgn_i.xhi >= x_i);
  assign in_y   = (rgn_i.ylo <= y_i) && (rgn_i.yhi >= y_i);
  assign min_ok = (rgn_i.min_mod & mods_i) == rgn_i.min_mod;
  assign max_ok = (rgn_i.max_mod & mods_i) == mods_i;
  assign hit_o  = in_x && in_y && min_ok && max_ok;

endmodule

### rtl/core/region_stack_hit_dispatcher.sv
// ----------------------------------------------------------------------------
// region_stack_hit_dispatcher
// Priority stack of pointer regions with hit testing and event dispatch.
// ----------------------------------------------------------------------------
// One item is handled at a time; the input is stalled until the last result
// beat of the item has been taken. Region records and the stack order live in
// two memories with a registered read. Each has a single read port, so stack
// entries are handled one at a time: a pointer event with a move or down flag
// examines stack entries until one is hit; push shifts entries; pop, raise and
// lower search and shift entries. No clearing pass is needed after reset.
module region_stack_hit_dispatcher
  import rshd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [EV_W-1:0]       cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [SLOT_W-1:0]     region_i,
  input  logic [SLOT_W-1:0]     ref_region_i,
  input  logic                  has_ref_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  logic [COORD_BITS-1:0] x_high_i,
  input  logic [COORD_BITS-1:0] y_high_i,
  input  logic [MOD_W-1:0]      modifiers_i,
  input  logic [MOD_W-1:0]      max_modifiers_i,
  input  logic [EV_W-1:0]       event_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [SLOT_W-1:0]     target_o,
  output logic [EV_W-1:0]       event_type_o,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [MOD_W-1:0]      out_modifiers_o,
  output logic [SLOT_W-1:0]     top_region_o,
  output logic                  stack_empty_o,
  output logic                  last_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DEC     = 5'd1;
  localparam logic [4:0] S_B_RD    = 5'd2;
  localparam logic [4:0] S_B_LAT   = 5'd3;
  localparam logic [4:0] S_FIND_RD = 5'd4;
  localparam logic [4:0] S_FIND_CK = 5'd5;
  localparam logic [4:0] S_REM_RD  = 5'd6;
  localparam logic [4:0] S_REM_WR  = 5'd7;
  localparam logic [4:0] S_INS_RD  = 5'd8;
  localparam logic [4:0] S_INS_WR  = 5'd9;
  localparam logic [4:0] S_INS_PUT = 5'd10;
  localparam logic [4:0] S_TOP     = 5'd11;
  localparam logic [4:0] S_TOP_LAT = 5'd12;
  localparam logic [4:0] S_SC_ORD  = 5'd13;
  localparam logic [4:0] S_SC_REG  = 5'd14;
  localparam logic [4:0] S_SC_CMP  = 5'd15;
  localparam logic [4:0] S_EV_RD   = 5'd16;
  localparam logic [4:0] S_EV_LAT  = 5'd17;
  localparam logic [4:0] S_EV_RES  = 5'd18;
  localparam logic [4:0] S_OUT_LV  = 5'd19;
  localparam logic [4:0] S_OUT_EN  = 5'd20;
  localparam logic [4:0] S_OUT_FIN = 5'd21;

  logic [4:0] state_q, state_d;

  // latched input beat
  logic [OP_W-1:0]       op_q;
  logic [SLOT_W-1:0]     r_q, ref_q;
  logic                  hasref_q;
  logic [COORD_BITS-1:0] x_q, y_q, xh_q, yh_q;
  logic [MOD_W-1:0]      mods_q, maxm_q;
  logic [EV_W-1:0]       ev_q;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NREG-1:0] slot_q, slot_d;
  logic            cur_vld_q, cur_vld_d;
  logic [IDXW-1:0] cur_q, cur_d;
  logic            cur_lv_q, cur_lv_d;
  logic            dflt_q;
  logic [EV_W-1:0] bare_q;
  logic [IDXW-1:0] top_q, top_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic [CNTW-1:0] pos_q, pos_d;
  logic [IDXW-1:0] fs_q, fs_d;
  logic [IDXW-1:0] b_q, b_d;
  logic            ph_q, ph_d;
  logic            hit_q, hit_d;
  logic [IDXW-1:0] h_q, h_d;
  region_t         rd_q, rd_d;
  logic            en_q, en_d;
  logic [IDXW-1:0] lv_tgt_q, lv_tgt_d;
  logic [KIND_W-1:0]     fin_kind_q, fin_kind_d;
  logic [SLOT_W-1:0]     fin_tgt_q, fin_tgt_d;
  logic [EV_W-1:0]       fin_ev_q, fin_ev_d;
  logic [COORD_BITS-1:0] fin_x_q, fin_x_d;
  logic [COORD_BITS-1:0] fin_y_q, fin_y_d;
  logic [MOD_W-1:0]      fin_mods_q, fin_mods_d;

  // memory ports
  logic            ord_we;
  logic [IDXW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic            rgn_we;
  logic [IDXW-1:0] rgn_raddr;
  region_t         rgn_wdata, rgn_rdata;
  logic            rgn_hit;

  logic            in_acc;
  logic [IDXW-1:0] r_idx, ref_idx;
  logic            r_ok, ref_ok, use_r, use_ref, chg, lv_now, en_now;

  rshd_ram #(.W(IDXW), .D(NREG)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  rshd_ram #(.W(RGN_W), .D(NREG)) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (rgn_we),
    .waddr_i (r_idx),
    .wdata_i (rgn_wdata),
    .raddr_i (rgn_raddr),
    .rdata_o (rgn_rdata)
  );

  rshd_match u_match (
    .rgn_i  (rgn_rdata),
    .x_i    (x_q),
    .y_i    (y_q),
    .mods_i (mods_q),
    .hit_o  (rgn_hit)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  assign r_idx   = r_q[IDXW-1:0];
  assign ref_idx = ref_q[IDXW-1:0];
  assign r_ok    = CNTW'(r_q) < CNTW'(NREG);
  assign ref_ok  = CNTW'(ref_q) < CNTW'(NREG);
  assign use_r   = r_ok && slot_q[r_idx];
  assign use_ref = ref_ok && slot_q[ref_idx];

  assign rgn_wdata = '{xlo: x_q, ylo: y_q, xhi: xh_q, yhi: yh_q,
                       min_mod: mods_q, max_mod: maxm_q, mask: ev_q};

  assign chg    = (hit_q != cur_vld_q) || (hit_q && (h_q != cur_q));
  assign lv_now = chg && cur_vld_q && cur_lv_q;
  assign en_now = chg && hit_q && (|(rd_q.mask & EV_ENTER));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    cur_vld_d  = cur_vld_q;
    cur_d      = cur_q;
    cur_lv_d   = cur_lv_q;
    top_d      = top_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    fs_d       = fs_q;
    b_d        = b_q;
    ph_d       = ph_q;
    hit_d      = hit_q;
    h_d        = h_q;
    rd_d       = rd_q;
    en_d       = en_q;
    lv_tgt_d   = lv_tgt_q;
    fin_kind_d = fin_kind_q;
    fin_tgt_d  = fin_tgt_q;
    fin_ev_d   = fin_ev_q;
    fin_x_d    = fin_x_q;
    fin_y_d    = fin_y_q;
    fin_mods_d = fin_mods_q;
    ord_we     = 1'b0;
    ord_waddr  = idx_q[IDXW-1:0];
    ord_wdata  = ord_rdata;
    ord_raddr  = idx_q[IDXW-1:0];
    rgn_we     = 1'b0;
    rgn_raddr  = h_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        fin_kind_d = KIND_DONE;
        fin_tgt_d  = r_q;
        fin_ev_d   = '0;
        fin_x_d    = '0;
        fin_y_d    = '0;
        fin_mods_d = '0;
        fs_d       = r_idx;
        ph_d       = 1'b0;
        idx_d      = '0;
        unique case (op_q)
          OP_PUSH: begin
            if (!r_ok || slot_q[r_idx] || (cnt_q >= CNTW'(NREG))) begin
              fin_kind_d = KIND_ERROR;
              state_d    = S_OUT_FIN;
            end else begin
              rgn_we         = 1'b1;
              slot_d[r_idx]  = 1'b1;
              pos_d          = '0;
              idx_d          = cnt_q;
              state_d        = S_INS_RD;
            end
          end
          OP_POP: begin
            if (!use_r) begin
              fin_kind_d = KIND_ERROR;
              state_d    = S_OUT_FIN;
            end else begin
              state_d = S_FIND_RD;
            end
          end
          OP_RAISE, OP_LOWER: begin
            if (!use_r || (hasref_q && !use_ref)) begin
              fin_kind_d = KIND_ERROR;
              state_d    = S_OUT_FIN;
            end else if (hasref_q) begin
              b_d     = ref_idx;
              state_d = (ref_idx == r_idx) ? S_OUT_FIN : S_FIND_RD;
            end else begin
              state_d = S_B_RD;
            end
          end
          OP_EVENT: begin
            if (|(ev_q & (EV_MOVE | EV_DOWN))) begin
              hit_d   = 1'b0;
              state_d = S_SC_ORD;
            end else begin
              hit_d   = cur_vld_q;
              h_d     = cur_q;
              state_d = cur_vld_q ? S_EV_RD : S_EV_RES;
            end
          end
          default: begin
            fin_kind_d = KIND_ERROR;
            state_d    = S_OUT_FIN;
          end
        endcase
      end
      S_B_RD: begin
        ord_raddr = (op_q == OP_RAISE) ? '0 : IDXW'(cnt_q - 1'b1);
        state_d   = S_B_LAT;
      end
      S_B_LAT: begin
        b_d     = ord_rdata;
        state_d = (ord_rdata == r_idx) ? S_OUT_FIN : S_FIND_RD;
      end
      S_FIND_RD: begin
        state_d = S_FIND_CK;
      end
      S_FIND_CK: begin
        if (ord_rdata == fs_q) begin
          if (!ph_q) begin
            state_d = S_REM_RD;
          end else begin
            pos_d   = idx_q + CNTW'(op_q == OP_LOWER);
            idx_d   = cnt_q;
            state_d = S_INS_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_REM_RD: begin
        ord_raddr = IDXW'(idx_q + 1'b1);
        if ((idx_q + 1'b1) < cnt_q) begin
          state_d = S_REM_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (op_q == OP_POP) begin
            slot_d[r_idx] = 1'b0;
            if (cur_vld_q && (cur_q == r_idx)) begin
              cur_vld_d = 1'b0;
              cur_d     = '0;
            end
            state_d = S_TOP;
          end else begin
            fs_d    = b_q;
            ph_d    = 1'b1;
            idx_d   = '0;
            state_d = S_FIND_RD;
          end
        end
      end
      S_REM_WR: begin
        ord_we  = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_REM_RD;
      end
      S_INS_RD: begin
        ord_raddr = IDXW'(idx_q - 1'b1);
        state_d   = (idx_q > pos_q) ? S_INS_WR : S_INS_PUT;
      end
      S_INS_WR: begin
        ord_we  = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = S_INS_RD;
      end
      S_INS_PUT: begin
        ord_we    = 1'b1;
        ord_waddr = pos_q[IDXW-1:0];
        ord_wdata = r_idx;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_TOP;
      end
      S_TOP: begin
        ord_raddr = '0;
        state_d   = (cnt_q == '0) ? S_OUT_FIN : S_TOP_LAT;
      end
      S_TOP_LAT: begin
        top_d   = ord_rdata;
        state_d = S_OUT_FIN;
      end
      S_SC_ORD: begin
        state_d = (idx_q < cnt_q) ? S_SC_REG : S_EV_RES;
      end
      S_SC_REG: begin
        rgn_raddr = ord_rdata;
        h_d       = ord_rdata;
        state_d   = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (rgn_hit) begin
          hit_d   = 1'b1;
          rd_d    = rgn_rdata;
          state_d = S_EV_RES;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SC_ORD;
        end
      end
      S_EV_RD: begin
        state_d = S_EV_LAT;
      end
      S_EV_LAT: begin
        rd_d    = rgn_rdata;
        state_d = S_EV_RES;
      end
      S_EV_RES: begin
        en_d       = en_now;
        lv_tgt_d   = cur_q;
        cur_vld_d  = hit_q;
        cur_d      = hit_q ? h_q : '0;
        cur_lv_d   = hit_q && (|(rd_q.mask & EV_LEAVE));
        fin_ev_d   = ev_q;
        fin_mods_d = mods_q;
        fin_x_d    = x_q;
        fin_y_d    = y_q;
        if (hit_q) begin
          fin_tgt_d = SLOT_W'(h_q);
          if ((ev_q & bare_q & rd_q.mask) == '0) begin
            fin_kind_d = KIND_DISCARD;
          end else begin
            fin_kind_d = KIND_DELIVER;
            fin_x_d    = x_q - rd_q.xlo;
            fin_y_d    = y_q - rd_q.ylo;
          end
        end else begin
          fin_tgt_d  = '0;
          fin_kind_d = dflt_q ? KIND_DEFAULT : KIND_DISCARD;
        end
        state_d = lv_now ? S_OUT_LV : (en_now ? S_OUT_EN : S_OUT_FIN);
      end
      S_OUT_LV: begin
        if (!out_stall_i) begin
          state_d = en_q ? S_OUT_EN : S_OUT_FIN;
        end
      end
      S_OUT_EN: begin
        if (!out_stall_i) begin
          state_d = S_OUT_FIN;
        end
      end
      S_OUT_FIN: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      slot_q    <= '0;
      cur_vld_q <= 1'b0;
      cur_q     <= '0;
      cur_lv_q  <= 1'b0;
      dflt_q    <= 1'b0;
      bare_q    <= BARE_MASK_RST;
      top_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      cur_vld_q <= cur_vld_d;
      cur_q     <= cur_d;
      cur_lv_q  <= cur_lv_d;
      top_q     <= top_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEFAULT: dflt_q <= cfg_data_i[0];
          CFG_BARE:    bare_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= operation_i;
      r_q      <= region_i;
      ref_q    <= ref_region_i;
      hasref_q <= has_ref_i;
      x_q      <= x_i;
      y_q      <= y_i;
      xh_q     <= x_high_i;
      yh_q     <= y_high_i;
      mods_q   <= modifiers_i;
      maxm_q   <= max_modifiers_i;
      ev_q     <= event_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    fs_q       <= fs_d;
    b_q        <= b_d;
    ph_q       <= ph_d;
    hit_q      <= hit_d;
    h_q        <= h_d;
    rd_q       <= rd_d;
    en_q       <= en_d;
    lv_tgt_q   <= lv_tgt_d;
    fin_kind_q <= fin_kind_d;
    fin_tgt_q  <= fin_tgt_d;
    fin_ev_q   <= fin_ev_d;
    fin_x_q    <= fin_x_d;
    fin_y_q    <= fin_y_d;
    fin_mods_q <= fin_mods_d;
  end

  // result beat mux: leave notice, enter notice, then the final beat
  always_comb begin
    out_valid_o     = 1'b0;
    kind_o          = fin_kind_q;
    target_o        = fin_tgt_q;
    event_type_o    = fin_ev_q;
    out_x_o         = fin_x_q;
    out_y_o         = fin_y_q;
    out_modifiers_o = fin_mods_q;
    last_o          = 1'b0;
    unique case (state_q)
      S_OUT_LV: begin
        out_valid_o     = 1'b1;
        kind_o          = KIND_LEAVE;
        target_o        = SLOT_W'(lv_tgt_q);
        event_type_o    = EV_LEAVE;
        out_x_o         = x_q;
        out_y_o         = y_q;
        out_modifiers_o = mods_q;
      end
      S_OUT_EN: begin
        out_valid_o     = 1'b1;
        kind_o          = KIND_ENTER;
        target_o        = SLOT_W'(h_q);
        event_type_o    = EV_ENTER;
        out_x_o         = x_q;
        out_y_o         = y_q;
        out_modifiers_o = mods_q;
      end
      S_OUT_FIN: begin
        out_valid_o = 1'b1;
        last_o      = 1'b1;
      end
      default: ;
    endcase
  end

  assign stack_empty_o = (cnt_q == '0);
  assign top_region_o  = (cnt_q == '0) ? '0 : SLOT_W'(top_q);

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(NREG))
    else $error("stack count beyond capacity");

  a_slots_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(slot_q) == int'(cnt_q)))
    else $error("slots in use disagree with stack count");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (state_q == S_IDLE))
    else $error("final beat taken but block not idle");

  a_cur_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cur_vld_q) |-> slot_q[cur_q])
    else $error("current region is not in use");
`endif

endmodule

### tb/sv/region_stack_hit_dispatcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_stack_hit_dispatcher_tb
// Self-checking bench: a directed table of stack operations and pointer
// events, then constrained-by-hand random traffic in three idle patterns.
// Every result beat is compared with a behavioral model of the region stack.
// ----------------------------------------------------------------------------
module region_stack_hit_dispatcher_tb;
  import rshd_pkg::*;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [SLOT_W-1:0]     rgn;
    logic [SLOT_W-1:0]     ref_rgn;
    logic                  has_ref;
    logic [COORD_BITS-1:0] x, y, xh, yh;
    logic [MOD_W-1:0]      mods, maxm;
    logic [EV_W-1:0]       ev;
  } item_t;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [SLOT_W-1:0]     target;
    logic [EV_W-1:0]       ev;
    logic [COORD_BITS-1:0] x, y;
    logic [MOD_W-1:0]      mods;
    logic [SLOT_W-1:0]     top;
    logic                  empty;
    logic                  last;
  } beat_t;

  typedef struct {
    item_t             it;
    bit                typed;
    logic [KIND_W-1:0] t_kind;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [EV_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] operation_i = '0;
  logic [SLOT_W-1:0] region_i = '0, ref_region_i = '0;
  logic has_ref_i = 1'b0;
  logic [COORD_BITS-1:0] x_i = '0, y_i = '0, x_high_i = '0, y_high_i = '0;
  logic [MOD_W-1:0] modifiers_i = '0, max_modifiers_i = '0;
  logic [EV_W-1:0] event_bits_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [SLOT_W-1:0] target_o, top_region_o;
  logic [EV_W-1:0] event_type_o;
  logic [COORD_BITS-1:0] out_x_o, out_y_o;
  logic [MOD_W-1:0] out_modifiers_o;
  logic stack_empty_o, last_o;

  region_stack_hit_dispatcher u_top (.*);

  always #2 clk_i = ~clk_i;

  // model state
  region_t         rgn_db[NREG];
  logic [SLOT_W-1:0] order[NREG];
  int              depth;
  logic [NREG-1:0] used;
  bit              cur_v;
  logic [SLOT_W-1:0] cur;
  bit              dflt_on;
  logic [EV_W-1:0] bare_mask;

  beat_t pending_beats[$];
  int    fail_cnt = 0;
  int    beats_seen = 0, items_sent = 0, hits_seen = 0;
  int    tx_pct = 0, rx_pct = 0;
  bit    hold_req = 0;
  int    hold_left = 0;

  function automatic int pos_of(logic [SLOT_W-1:0] s);
    for (int p = 0; p < depth; p++) if (order[p] == s) return p;
    return depth;
  endfunction

  function automatic void remove_slot(logic [SLOT_W-1:0] s);
    int p;
    p = pos_of(s);
    if (p >= depth) return;
    for (; p + 1 < depth; p++) order[p] = order[p+1];
    depth--;
  endfunction

  function automatic void insert_at(int p, logic [SLOT_W-1:0] s);
    if (depth >= NREG || p > depth) return;
    for (int i = depth; i > p; i--) order[i] = order[i-1];
    order[p] = s;
    depth++;
  endfunction

  function automatic beat_t mk_beat(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] t,
                                    logic [EV_W-1:0] e, logic [COORD_BITS-1:0] bx,
                                    logic [COORD_BITS-1:0] by, logic [MOD_W-1:0] m);
    beat_t b;
    b.kind = k; b.target = t; b.ev = e; b.x = bx; b.y = by; b.mods = m;
    b.top = '0; b.empty = 1'b0; b.last = 1'b0;
    return b;
  endfunction

  task automatic dispatch_model(input item_t it, output beat_t res[3], output int n);
    bit err, hit;
    logic [SLOT_W-1:0] h, b;
    region_t g;
    err = 0;
    n = 0;
    case (it.op)
      OP_PUSH: begin
        if (used[it.rgn] || depth >= NREG) err = 1;
        else begin
          rgn_db[it.rgn] = '{it.x, it.y, it.xh, it.yh, it.mods, it.maxm, it.ev};
          used[it.rgn] = 1'b1;
          insert_at(0, it.rgn);
        end
      end
      OP_POP: begin
        if (!used[it.rgn]) err = 1;
        else begin
          remove_slot(it.rgn);
          used[it.rgn] = 1'b0;
          if (cur_v && cur == it.rgn) cur_v = 0;
        end
      end
      OP_RAISE, OP_LOWER: begin
        if (!used[it.rgn] || (it.has_ref && !used[it.ref_rgn])) err = 1;
        else begin
          if (it.has_ref) b = it.ref_rgn;
          else b = (it.op == OP_RAISE) ? order[0] : order[depth-1];
          if (b != it.rgn) begin
            remove_slot(it.rgn);
            insert_at(pos_of(b) + ((it.op == OP_LOWER) ? 1 : 0), it.rgn);
          end
        end
      end
      OP_EVENT: begin
        hit = cur_v;
        h = cur;
        if ((it.ev & (EV_MOVE | EV_DOWN)) != 0) begin
          hit = 0;
          for (int p = 0; p < depth; p++) begin
            g = rgn_db[order[p]];
            if (g.xlo <= it.x && g.xhi >= it.x && g.ylo <= it.y && g.yhi >= it.y &&
                (g.min_mod & it.mods) == g.min_mod && (g.max_mod & it.mods) == it.mods) begin
              hit = 1;
              h = order[p];
              break;
            end
          end
        end
        if (hit != cur_v || (hit && h != cur)) begin
          if (cur_v && (rgn_db[cur].mask & EV_LEAVE) != 0)
            res[n++] = mk_beat(KIND_LEAVE, cur, EV_LEAVE, it.x, it.y, it.mods);
          if (hit && (rgn_db[h].mask & EV_ENTER) != 0)
            res[n++] = mk_beat(KIND_ENTER, h, EV_ENTER, it.x, it.y, it.mods);
        end
        cur_v = hit;
        cur = hit ? h : '0;
        if (hit) begin
          g = rgn_db[h];
          hits_seen++;
          if ((it.ev & bare_mask & g.mask) == 0)
            res[n++] = mk_beat(KIND_DISCARD, h, it.ev, it.x, it.y, it.mods);
          else
            res[n++] = mk_beat(KIND_DELIVER, h, it.ev, it.x - g.xlo, it.y - g.ylo, it.mods);
        end else if (dflt_on) begin
          res[n++] = mk_beat(KIND_DEFAULT, '0, it.ev, it.x, it.y, it.mods);
        end else begin
          res[n++] = mk_beat(KIND_DISCARD, '0, it.ev, it.x, it.y, it.mods);
        end
      end
      default: err = 1;
    endcase
    if (it.op != OP_EVENT) begin
      res[0] = mk_beat(err ? KIND_ERROR : KIND_DONE, it.rgn, '0, '0, '0, '0);
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      res[k].top = depth ? order[0] : '0;
      res[k].empty = (depth == 0);
      res[k].last = (k == n - 1);
    end
  endtask

  task automatic chk_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // result side: random stall, long hold-off on request, compare each beat
  always @(posedge clk_i) begin
    beat_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat, kind %0d", kind_o);
        fail_cnt++;
      end else begin
        w = pending_beats.pop_front();
        chk_field("kind", w.kind, kind_o);
        chk_field("target", w.target, target_o);
        chk_field("event_type", w.ev, event_type_o);
        chk_field("out_x", w.x, out_x_o);
        chk_field("out_y", w.y, out_y_o);
        chk_field("out_modifiers", w.mods, out_modifiers_o);
        chk_field("top_region", w.top, top_region_o);
        chk_field("stack_empty", w.empty, stack_empty_o);
        chk_field("last", w.last, last_o);
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send_item(input item_t it, input bit typed = 0,
                           input logic [KIND_W-1:0] t_kind = KIND_DONE);
    beat_t res[3];
    int n;
    if ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= it.op; region_i <= it.rgn; ref_region_i <= it.ref_rgn;
    has_ref_i <= it.has_ref; x_i <= it.x; y_i <= it.y; x_high_i <= it.xh;
    y_high_i <= it.yh; modifiers_i <= it.mods; max_modifiers_i <= it.maxm;
    event_bits_i <= it.ev;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    dispatch_model(it, res, n);
    if (typed) begin
      // after reset: single beat, empty stack
      res[0] = mk_beat(t_kind, it.rgn, '0, '0, '0, '0);
      res[0].empty = 1'b1;
      res[0].last = 1'b1;
      n = 1;
    end
    for (int k = 0; k < n; k++) pending_beats.push_back(res[k]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [EV_W-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEFAULT) dflt_on = val[0];
    else bare_mask = val;
  endtask

  function automatic item_t mk(logic [OP_W-1:0] op, logic [SLOT_W-1:0] r,
                               logic [SLOT_W-1:0] rf, logic hr,
                               int x, int y, int xh, int yh,
                               int m, int mm, int ev);
    item_t it;
    it = '{op, r, rf, hr, x, y, xh, yh, m, mm, ev};
    return it;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(bit want_used);
    logic [SLOT_W-1:0] s;
    for (int t = 0; t < 40; t++) begin
      s = $urandom_range(NREG - 1);
      if (used[s] == want_used) return s;
    end
    return $urandom_range(NREG - 1);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int sel, w;
    region_t g;
    it = mk($urandom_range(4), $urandom_range(15), $urandom_range(15), $urandom_range(1),
            $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
            $urandom_range(4095), $urandom_range(255), $urandom_range(255),
            $urandom_range(2047));
    sel = $urandom_range(99);
    if (sel < 4) begin
      it.op = $urandom_range(5, 7);
    end else if (sel < 30 - depth) begin
      it.op = OP_PUSH;
      it.rgn = pick_slot(0);
      w = ($urandom_range(9) == 0) ? 4095 : $urandom_range(400);
      it.xh = (it.x + w > 4095) ? 4095 : it.x + w;
      w = ($urandom_range(9) == 0) ? 4095 : $urandom_range(400);
      it.yh = (it.y + w > 4095) ? 4095 : it.y + w;
      if ($urandom_range(19) == 0) it.xh = it.x - 1;
      it.mods = $urandom & $urandom & $urandom;
      if ($urandom_range(2) != 0) it.maxm = 8'hff;
      if ($urandom_range(3) != 0) it.ev = it.ev | EV_ENTER | EV_LEAVE | EV_MOVE;
    end else if (sel < 38) begin
      it.op = OP_POP;
      it.rgn = pick_slot($urandom_range(9) != 0);
    end else if (sel < 52) begin
      it.op = $urandom_range(1) ? OP_RAISE : OP_LOWER;
      it.rgn = pick_slot($urandom_range(9) != 0);
      it.ref_rgn = pick_slot($urandom_range(9) != 0);
    end else begin
      it.op = OP_EVENT;
      if ($urandom_range(3) != 0) it.ev = it.ev | (($urandom_range(1)) ? EV_MOVE : EV_DOWN);
      if (depth != 0 && $urandom_range(4) != 0) begin
        g = rgn_db[order[$urandom_range(depth - 1)]];
        if (g.xhi >= g.xlo) it.x = g.xlo + $urandom_range(g.xhi - g.xlo);
        if (g.yhi >= g.ylo) it.y = g.ylo + $urandom_range(g.yhi - g.ylo);
        if ($urandom_range(3) != 0) it.mods = g.min_mod | ($urandom & g.max_mod);
      end
    end
    return it;
  endfunction

  initial begin
    dir_row_t rows[$];
    int pat_tx[3] = '{21, 54, 0};
    int pat_rx[3] = '{54, 21, 0};
    depth = 0; used = '0; cur_v = 0; cur = '0; dflt_on = 0; bare_mask = BARE_MASK_RST;
    foreach (rgn_db[i]) rgn_db[i] = '0;
    foreach (order[i]) order[i] = '0;

    rows.push_back('{mk(OP_POP, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, KIND_ERROR});
    rows.push_back('{mk(3'd7, 15, 15, 1, 4095, 4095, 4095, 4095, 255, 255, 2047),
                     1, KIND_ERROR});
    rows.push_back('{mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, KIND_ERROR});
    rows.push_back('{mk(OP_RAISE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, KIND_ERROR});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, KIND_DONE});
    rows.push_back('{mk(OP_PUSH, 0, 0, 0, 0, 0, 4095, 4095, 0, 255, 2047), 0, KIND_DONE});
    rows.push_back('{mk(OP_PUSH, 15, 0, 0, 100, 100, 200, 200, 1, 15, 1541), 0, KIND_DONE});
    rows.push_back('{mk(OP_PUSH, 0, 0, 0, 1, 1, 2, 2, 0, 0, 0), 0, KIND_DONE});
    // empty box never hits
    rows.push_back('{mk(OP_PUSH, 5, 0, 0, 300, 0, 200, 4095, 0, 255, 2047), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 150, 150, 0, 0, 1, 0, 1), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 150, 150, 0, 0, 0, 0, 1), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 4095, 4095, 0, 0, 255, 0, 4), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 7, 9, 0, 0, 3, 0, 2), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 7, 9, 0, 0, 3, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 250, 2000, 0, 0, 1, 0, 16), 0, KIND_DONE});
    rows.push_back('{mk(OP_RAISE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    // move and down at 120,120: region 0, raised to the top, takes the hit over region 15
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 120, 120, 0, 0, 1, 0, 5), 0, KIND_DONE});
    rows.push_back('{mk(OP_LOWER, 0, 15, 1, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 15, 0, 0, 50, 60, 0, 0, 1, 0, 2), 0, KIND_DONE});
    rows.push_back('{mk(OP_RAISE, 15, 15, 1, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_LOWER, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_LOWER, 0, 9, 1, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, KIND_DONE});
    rows.push_back('{mk(OP_EVENT, 0, 0, 0, 4000, 4000, 0, 0, 0, 0, 1), 0, KIND_DONE});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].t_kind);
    drain();
    write_cfg(CFG_DEFAULT, 11'd1);
    write_cfg(CFG_BARE, 11'd2047);
    send_item(mk(OP_EVENT, 0, 0, 0, 4000, 4000, 0, 0, 0, 0, 4));

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin write_cfg(CFG_DEFAULT, 11'd0); write_cfg(CFG_BARE, 11'd0); end
        1: begin write_cfg(CFG_DEFAULT, 11'd1); write_cfg(CFG_BARE, $urandom_range(2047)); end
        default: begin write_cfg(CFG_DEFAULT, 11'd0); write_cfg(CFG_BARE, 11'd2047); end
      endcase
      tx_pct = pat_tx[ph];
      rx_pct = pat_rx[ph];
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 45; n++) begin
        send_item(rand_item());
        if (ph == 0 && n == 20) drain();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d items, %0d result beats, %0d region hits", items_sent,
             beats_seen, hits_seen);
    $display("stack ops, hit tests, notices and errors under three stall patterns");
    if (fail_cnt == 0 && pending_beats.size() == 0)
      $display("region_stack_hit_dispatcher regression: pass");
    else
      $display("region_stack_hit_dispatcher regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("region_stack_hit_dispatcher regression: fail");
    $finish;
  end

endmodule

### region_stack_hit_dispatcher.f
rtl/core/rshd_pkg.sv
rtl/core/rshd_ram.sv
rtl/core/rshd_match.sv
rtl/core/region_stack_hit_dispatcher.sv
tb/sv/region_stack_hit_dispatcher_tb.sv
